// ===== hw/rtl/lfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types, constants and the nonlinear filter of the lfsr stream cipher.
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int unsigned StateW  = 48;
  localparam int unsigned KeyLoW  = 32;
  localparam int unsigned KeyHiW  = 16;
  localparam int unsigned TagW    = 32;
  localparam int unsigned NonceW  = 32;
  localparam int unsigned DataW   = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned RoundW  = 6;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned InDataW = 80;

  localparam logic [RoundW-1:0] InitRounds = RoundW'(32);
  localparam logic [CountW-1:0] MaxBits    = CountW'(8);

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegReverse = 2'd2;

  // request kinds carried in tuser
  localparam logic ReqInit  = 1'b0;
  localparam logic ReqCrypt = 1'b1;

  // filter tables
  localparam logic [15:0] TabA = 16'h2C79;
  localparam logic [15:0] TabB = 16'h6671;
  localparam logic [31:0] TabC = 32'h7907287B;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } lfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } lfc_stat_t;

  // two-level nonlinear filter over five four-bit groups of state bits
  function automatic logic lfc_filter(input logic [StateW-1:0] x);
    logic [4:0] sel;
    begin
      sel[0] = TabA[{x[5], x[4], x[2], x[1]}];
      sel[1] = TabB[{x[14], x[13], x[11], x[7]}];
      sel[2] = TabB[{x[25], x[22], x[20], x[16]}];
      sel[3] = TabB[{x[32], x[30], x[28], x[27]}];
      sel[4] = TabA[{x[45], x[43], x[42], x[33]}];
      return TabC[sel];
    end
  endfunction

  // linear feedback bit of the register
  function automatic logic lfc_feedback(input logic [StateW-1:0] x);
    begin
      return x[0] ^ x[2] ^ x[3] ^ x[6] ^ x[7] ^ x[8] ^ x[16] ^ x[22] ^ x[23]
           ^ x[26] ^ x[30] ^ x[41] ^ x[42] ^ x[43] ^ x[46] ^ x[47];
    end
  endfunction

endpackage

// ===== hw/rtl/lfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfc_ctrl
// Sequencer: accepts a request, runs the datapath rounds, hands the result
// to the output register once that register is free.
// ----------------------------------------------------------------------------
module lfc_ctrl
  import lfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lfc_stat_t stat_i,
  output lfc_cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stat_i.done) begin
          cmd_o.step = 1'b1;
        end else if (!out_vld_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_vld_d = cmd_o.push | (out_vld_q & ~out_ready_i);
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

// ===== hw/rtl/lfc_dpath.sv =====
// ----------------------------------------------------------------------------
// lfc_dpath
// Cipher datapath: key registers, 48-bit lfsr, round counter, data and
// result registers and the output register.
// ----------------------------------------------------------------------------
module lfc_dpath
  import lfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               req_type_i,
  input  logic [TagW-1:0]    tag_id_i,
  input  logic [NonceW-1:0]  nonce_i,
  input  logic [DataW-1:0]   data_byte_i,
  input  logic [CountW-1:0]  bit_count_i,
  input  lfc_cmd_t           cmd_i,
  output lfc_stat_t          stat_o,
  output logic [DataW-1:0]   out_byte_o
);

  logic [KeyLoW-1:0] key_lo_q;
  logic [KeyHiW-1:0] key_hi_q;
  logic              rev_q;

  logic [StateW-1:0] lfsr_q;
  logic [NonceW-1:0] mix_q;
  logic [RoundW-1:0] rnd_q;
  logic [PosW-1:0]   pos_q;
  logic              mode_q;
  logic [DataW-1:0]  dat_q;
  logic [DataW-1:0]  res_q;
  logic [DataW-1:0]  out_q;

  logic [KeyLoW-1:0] kl_rev;
  logic [KeyHiW-1:0] kh_rev;
  logic [TagW-1:0]   tag_rev;
  logic [NonceW-1:0] nv_rev;
  logic [KeyLoW-1:0] kl_sel;
  logic [KeyHiW-1:0] kh_sel;
  logic [TagW-1:0]   tag_sel;
  logic [NonceW-1:0] nv_sel;
  logic [StateW-1:0] lfsr_shr;
  logic [StateW-1:0] lfsr_crypt;
  logic [CountW-1:0] cnt_sat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      rev_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKeyLow:  key_lo_q <= cfg_data_i[KeyLoW-1:0];
        RegKeyHigh: key_hi_q <= cfg_data_i[KeyHiW-1:0];
        RegReverse: rev_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // bit-reversed copies of key, nonce and tag id
  assign kl_rev  = {<<{key_lo_q}};
  assign kh_rev  = {<<{key_hi_q}};
  assign tag_rev = {<<{tag_id_i}};
  assign nv_rev  = {<<{nonce_i}};

  // optional bit reversal of key, nonce and tag id
  always_comb begin
    kl_sel  = rev_q ? kl_rev  : key_lo_q;
    kh_sel  = rev_q ? kh_rev  : key_hi_q;
    tag_sel = rev_q ? tag_rev : tag_id_i;
    nv_sel  = rev_q ? nv_rev  : nonce_i;
    cnt_sat = (bit_count_i > MaxBits) ? MaxBits : bit_count_i;
  end

  // one-step candidates of the lfsr
  assign lfsr_shr   = {1'b0, lfsr_q[StateW-1:1]};
  assign lfsr_crypt = {lfc_feedback(lfsr_q), lfsr_q[StateW-1:1]};

  // lfsr and round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= '0;
      rnd_q  <= '0;
    end else if (cmd_i.load) begin
      if (req_type_i == ReqInit) begin
        lfsr_q <= {kh_sel, tag_sel};
        rnd_q  <= InitRounds;
      end else begin
        rnd_q  <= RoundW'(cnt_sat);
      end
    end else if (cmd_i.step) begin
      rnd_q <= rnd_q - RoundW'(1);
      if (mode_q == ReqInit) begin
        lfsr_q <= {lfc_filter(lfsr_shr) ^ mix_q[0], lfsr_q[StateW-1:1]};
      end else begin
        lfsr_q <= lfsr_crypt;
      end
    end
  end

  // request payload, mixing word and result bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= req_type_i;
      mix_q  <= nv_sel ^ kl_sel;
      dat_q  <= data_byte_i;
      pos_q  <= PosW'(DataW - 1);
      res_q  <= '0;
    end else if (cmd_i.step) begin
      mix_q <= {1'b0, mix_q[NonceW-1:1]};
      if (mode_q == ReqCrypt) begin
        res_q[pos_q] <= lfc_filter(lfsr_crypt) ^ dat_q[pos_q];
        pos_q        <= pos_q - PosW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  assign stat_o.done = (rnd_q == '0);
  assign out_byte_o  = out_q;

endmodule

// ===== hw/rtl/lfsr_filter_stream_cipher.sv =====
// Operation: an init request runs InitRounds lfsr steps after acceptance, a crypt
// request bit_count steps with bit_count saturated at 8 (no step for a zero bit
// count); one lfsr step a cycle; the result then waits for a free output register.
// Requests: one at a time, a new one only once the last result is in the output
// register; the next request is taken while a result waits.
// Reset: asynchronous, active low; clears lfsr state, key registers, control.
// ----------------------------------------------------------------------------
// lfsr_filter_stream_cipher
// 48-bit lfsr stream cipher with a two-level nonlinear filter, stream ports.
// ----------------------------------------------------------------------------
module lfsr_filter_stream_cipher
  import lfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,  // tag_id, nonce, data_byte, bit_count, zero pad
  input  logic               s_axis_tuser,  // req_type
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata   // out_byte
);

  lfc_cmd_t         cmd;
  lfc_stat_t        stat;
  logic [DataW-1:0] out_byte;

  lfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lfc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_type_i  (s_axis_tuser),
    .tag_id_i    (s_axis_tdata[TagW-1:0]),
    .nonce_i     (s_axis_tdata[TagW+NonceW-1:TagW]),
    .data_byte_i (s_axis_tdata[TagW+NonceW+DataW-1:TagW+NonceW]),
    .bit_count_i (s_axis_tdata[TagW+NonceW+DataW+CountW-1:TagW+NonceW+DataW]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_byte_o  (out_byte)
  );

  assign m_axis_tdata = out_byte;

endmodule

// ===== hw/rtl/lfc_checker.sv =====
// ----------------------------------------------------------------------------
// lfc_checker
// Port-level checks of the cipher's stream behavior over time.
// ----------------------------------------------------------------------------
module lfc_checker
  import lfc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata
);

  // no result is offered once reset has been seen at a clock edge
  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

  // a stalled result holds its data
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // the block is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // a result cannot appear in the cycle right after a request transaction
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind lfsr_filter_stream_cipher lfc_checker u_lfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
